[rtl/core/source_byte_tokenizer_defines.svh]
// Assertion helpers for the tokenizer. Both take a label, a clock, a reset, a
// triggering condition, a consequence and a message.
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/sbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sbt_pkg;

  // Token kinds in their output encoding.
  typedef enum logic [5:0] {
    TK_NUMBER = 6'd0, TK_STRING = 6'd1, TK_IDENT = 6'd2,
    TK_KW_CETAK = 6'd3, TK_KW_VAR = 6'd4, TK_KW_KONSTAN = 6'd5, TK_KW_FUNGSI = 6'd6,
    TK_KW_KEMBALI = 6'd7, TK_KW_JIKA = 6'd8, TK_KW_LAIN = 6'd9, TK_KW_SELAMA = 6'd10,
    TK_KW_UNTUK = 6'd11, TK_KW_DALAM = 6'd12, TK_KW_BENAR = 6'd13, TK_KW_SALAH = 6'd14,
    TK_KW_KOSONG = 6'd15, TK_KW_DAN = 6'd16, TK_KW_ATAU = 6'd17, TK_KW_BUKAN = 6'd18,
    TK_KW_PUTUS = 6'd19, TK_KW_LANJUT = 6'd20,
    TK_PLUS = 6'd21, TK_MINUS = 6'd22, TK_STAR = 6'd23, TK_SLASH = 6'd24,
    TK_PERCENT = 6'd25, TK_POW = 6'd26, TK_ASSIGN = 6'd27, TK_PLUS_EQ = 6'd28,
    TK_MINUS_EQ = 6'd29, TK_STAR_EQ = 6'd30, TK_SLASH_EQ = 6'd31, TK_EQ = 6'd32,
    TK_NE = 6'd33, TK_LT = 6'd34, TK_GT = 6'd35, TK_LE = 6'd36, TK_GE = 6'd37,
    TK_AND_AND = 6'd38, TK_OR_OR = 6'd39, TK_BANG = 6'd40, TK_INC = 6'd41,
    TK_DEC = 6'd42, TK_ARROW = 6'd43, TK_DOT = 6'd44, TK_RANGE = 6'd45,
    TK_LPAREN = 6'd46, TK_RPAREN = 6'd47, TK_LBRACE = 6'd48, TK_RBRACE = 6'd49,
    TK_LBRACK = 6'd50, TK_RBRACK = 6'd51, TK_COMMA = 6'd52, TK_SEMI = 6'd53,
    TK_COLON = 6'd54, TK_QUESTION = 6'd55, TK_END = 6'd56, TK_BAD = 6'd57
  } kind_e;

  // Whitespace, quote and backslash characters, given by their byte codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [3:0]  FRAC_KEEP = 4'd9;

  // One input word.
  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_marker;
  } in_t;

  // One output word.
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [19:0] token_line;
    logic [23:0] token_offset;
    logic [15:0] token_length;
    logic [31:0] int_part;
    logic [29:0] frac_part;
    logic [3:0]  frac_digits;
    logic        last_of_run;
  } out_t;

  // One token as built by the lexer.
  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] line;
    logic [23:0] offset;
    logic [15:0] length;
    logic [31:0] int_part;
    logic [29:0] frac_part;
    logic [3:0]  frac_digits;
  } tok_t;

  // All tokens caused by one input word.
  typedef struct packed {
    logic [1:0]       n;
    tok_t [2:0]       tok;
  } grp_t;

  // Result of a two-character operator lookup.
  typedef struct packed {
    logic  hit;
    logic  line_cmt;
    logic  blk_cmt;
    kind_e kind;
  } pair_res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic starts_pair(logic [7:0] c);
    return c inside {"*", "=", "!", "<", ">", "&", "|", "+", "-", "/", "."};
  endfunction

  function automatic pair_res_t pair_kind(logic [7:0] a, logic [7:0] b);
    pair_res_t r;
    r = '{hit: 1'b1, line_cmt: 1'b0, blk_cmt: 1'b0, kind: TK_BAD};
    case ({a, b})
      "**": r.kind = TK_POW;
      "==": r.kind = TK_EQ;
      "!=": r.kind = TK_NE;
      "<=": r.kind = TK_LE;
      ">=": r.kind = TK_GE;
      "&&": r.kind = TK_AND_AND;
      "||": r.kind = TK_OR_OR;
      "++": r.kind = TK_INC;
      "--": r.kind = TK_DEC;
      "=>": r.kind = TK_ARROW;
      "+=": r.kind = TK_PLUS_EQ;
      "-=": r.kind = TK_MINUS_EQ;
      "*=": r.kind = TK_STAR_EQ;
      "/=": r.kind = TK_SLASH_EQ;
      "..": r.kind = TK_RANGE;
      "//": begin
        r.hit = 1'b0;
        r.line_cmt = 1'b1;
      end
      "/*": begin
        r.hit = 1'b0;
        r.blk_cmt = 1'b1;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_e one_kind(logic [7:0] c);
    kind_e k;
    case (c)
      "+": k = TK_PLUS;
      "-": k = TK_MINUS;
      "*": k = TK_STAR;
      "/": k = TK_SLASH;
      "%": k = TK_PERCENT;
      "=": k = TK_ASSIGN;
      "<": k = TK_LT;
      ">": k = TK_GT;
      "!": k = TK_BANG;
      "(": k = TK_LPAREN;
      ")": k = TK_RPAREN;
      "{": k = TK_LBRACE;
      "}": k = TK_RBRACE;
      "[": k = TK_LBRACK;
      "]": k = TK_RBRACK;
      ",": k = TK_COMMA;
      ";": k = TK_SEMI;
      ":": k = TK_COLON;
      ".": k = TK_DOT;
      "?": k = TK_QUESTION;
      default: k = TK_BAD;
    endcase
    return k;
  endfunction

  // Keyword match; w holds the first seven name bytes, first byte on top.
  function automatic kind_e kw_kind(logic [55:0] w, logic [15:0] n);
    kind_e k;
    k = TK_IDENT;
    if      (n == 16'd5 && w[55:16] == "cetak")   k = TK_KW_CETAK;
    else if (n == 16'd3 && w[55:32] == "var")     k = TK_KW_VAR;
    else if (n == 16'd7 && w[55:0]  == "konstan") k = TK_KW_KONSTAN;
    else if (n == 16'd6 && w[55:8]  == "fungsi")  k = TK_KW_FUNGSI;
    else if (n == 16'd7 && w[55:0]  == "kembali") k = TK_KW_KEMBALI;
    else if (n == 16'd4 && w[55:24] == "jika")    k = TK_KW_JIKA;
    else if (n == 16'd4 && w[55:24] == "lain")    k = TK_KW_LAIN;
    else if (n == 16'd6 && w[55:8]  == "selama")  k = TK_KW_SELAMA;
    else if (n == 16'd5 && w[55:16] == "untuk")   k = TK_KW_UNTUK;
    else if (n == 16'd5 && w[55:16] == "dalam")   k = TK_KW_DALAM;
    else if (n == 16'd5 && w[55:16] == "benar")   k = TK_KW_BENAR;
    else if (n == 16'd5 && w[55:16] == "salah")   k = TK_KW_SALAH;
    else if (n == 16'd6 && w[55:8]  == "kosong")  k = TK_KW_KOSONG;
    else if (n == 16'd3 && w[55:32] == "dan")     k = TK_KW_DAN;
    else if (n == 16'd4 && w[55:24] == "atau")    k = TK_KW_ATAU;
    else if (n == 16'd5 && w[55:16] == "bukan")   k = TK_KW_BUKAN;
    else if (n == 16'd5 && w[55:16] == "putus")   k = TK_KW_PUTUS;
    else if (n == 16'd6 && w[55:8]  == "lanjut")  k = TK_KW_LANJUT;
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/core/sbt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module sbt_front import sbt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int OFFSET_BITS   = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  in_t  in_i,
  output logic push_o,
  output grp_t grp_o
);

  localparam int IdxW = $clog2(KEYWORD_CHARS);

  // Lexer modes.
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_OP    = 4'd1;
  localparam logic [3:0] M_LINE  = 4'd2;
  localparam logic [3:0] M_BLOCK = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_STR   = 4'd5;
  localparam logic [3:0] M_ESC   = 4'd6;
  localparam logic [3:0] M_INT   = 4'd7;
  localparam logic [3:0] M_NDOT  = 4'd8;
  localparam logic [3:0] M_FRAC  = 4'd9;
  localparam logic [3:0] M_IDENT = 4'd10;
  localparam logic [3:0] M_HALT  = 4'd11;

  logic [3:0]             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d, quote_q, quote_d;
  logic [15:0]            cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] start_q, start_d, off_q, off_d, off_prev;
  logic [19:0]            sline_q, sline_d, line_q, line_d;
  logic [31:0]            int_q, int_d, int_next;
  logic [29:0]            frac_q, frac_d, frac_next;
  logic [3:0]             fc_q, fc_d;
  logic [7:0]             buf_q [KEYWORD_CHARS];
  logic                   buf_we;
  logic [IdxW-1:0]        buf_idx;
  logic [7:0]             c;
  logic [3:0]             dig;
  logic [35:0]            int_prod;
  logic [15:0]            cnt_inc, cnt_inc2;
  logic [55:0]            name_w;
  pair_res_t              pk;
  kind_e                  k1;
  logic                   idle_go;
  grp_t                   grp_d;

  function automatic tok_t mk(kind_e k, logic [19:0] ln, logic [OFFSET_BITS-1:0] off,
                              logic [15:0] len, logic [31:0] ip, logic [29:0] fp,
                              logic [3:0] fd);
    tok_t t;
    t.kind        = k;
    t.line        = ln;
    t.offset      = 24'(off);
    t.length      = len;
    t.int_part    = ip;
    t.frac_part   = fp;
    t.frac_digits = fd;
    return t;
  endfunction

  // Shared arithmetic for the current byte.
  assign c         = in_i.src_byte;
  assign dig       = c[3:0];
  assign int_prod  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + 36'(dig);
  assign int_next  = (|int_prod[35:32]) ? 32'hFFFF_FFFF : int_prod[31:0];
  assign frac_next = (frac_q << 3) + (frac_q << 1) + 30'(dig);
  assign cnt_inc   = (cnt_q == LEN_MAX) ? LEN_MAX : cnt_q + 16'd1;
  assign cnt_inc2  = (cnt_q >= LEN_MAX - 16'd1) ? LEN_MAX : cnt_q + 16'd2;
  assign off_prev  = off_q - OFFSET_BITS'(1);
  assign name_w    = {buf_q[0], buf_q[1], buf_q[2], buf_q[3], buf_q[4], buf_q[5], buf_q[6]};
  assign pk        = pair_kind(pend_q, c);
  assign k1        = one_kind(pend_q);

  // Next state and the tokens that this word completes.
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    quote_d = quote_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    sline_d = sline_q;
    line_d  = line_q;
    off_d   = off_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fc_d    = fc_q;
    buf_we  = 1'b0;
    buf_idx = cnt_q[IdxW-1:0];
    idle_go = 1'b0;
    grp_d   = '0;
    if (fire_i && mode_q != M_HALT) begin
      if (in_i.end_marker) begin
        // Flush whatever is pending.
        case (mode_q) inside
          M_OP: begin
            grp_d.tok[grp_d.n] = mk(k1, sline_q, start_q, 16'd1, '0, '0, '0);
            grp_d.n = grp_d.n + 2'd1;
            if (k1 == TK_BAD) mode_d = M_HALT;
          end
          M_STR, M_ESC: begin
            grp_d.tok[grp_d.n] = mk(TK_STRING, sline_q, start_q, cnt_q, '0, '0, '0);
            grp_d.n = grp_d.n + 2'd1;
          end
          M_INT, M_FRAC: begin
            grp_d.tok[grp_d.n] = mk(TK_NUMBER, sline_q, start_q, cnt_q, int_q, frac_q, fc_q);
            grp_d.n = grp_d.n + 2'd1;
          end
          M_NDOT: begin
            grp_d.tok[grp_d.n] = mk(TK_NUMBER, sline_q, start_q, cnt_q, int_q, frac_q, fc_q);
            grp_d.n = grp_d.n + 2'd1;
            grp_d.tok[grp_d.n] = mk(TK_DOT, line_q, off_prev, 16'd1, '0, '0, '0);
            grp_d.n = grp_d.n + 2'd1;
          end
          M_IDENT: begin
            grp_d.tok[grp_d.n] = mk(kw_kind(name_w, cnt_q), sline_q, start_q, cnt_q,
                                    '0, '0, '0);
            grp_d.n = grp_d.n + 2'd1;
          end
          default: ;
        endcase
        // End token, then back to the reset state for the next source.
        if (mode_d != M_HALT) begin
          grp_d.tok[grp_d.n] = mk(TK_END, line_q, off_q, 16'd0, '0, '0, '0);
          grp_d.n = grp_d.n + 2'd1;
          mode_d  = M_IDLE;
          pend_d  = '0;
          quote_d = '0;
          cnt_d   = '0;
          start_d = '0;
          sline_d = 20'd1;
          line_d  = 20'd1;
          off_d   = '0;
          int_d   = '0;
          frac_d  = '0;
          fc_d    = '0;
        end
      end else begin
        unique case (mode_q)
          M_IDLE: idle_go = 1'b1;
          M_OP: begin
            if (pk.line_cmt) begin
              mode_d = M_LINE;
            end else if (pk.blk_cmt) begin
              mode_d = M_BLOCK;
            end else if (pk.hit) begin
              grp_d.tok[grp_d.n] = mk(pk.kind, sline_q, start_q, 16'd2, '0, '0, '0);
              grp_d.n = grp_d.n + 2'd1;
              mode_d  = M_IDLE;
            end else begin
              grp_d.tok[grp_d.n] = mk(k1, sline_q, start_q, 16'd1, '0, '0, '0);
              grp_d.n = grp_d.n + 2'd1;
              if (k1 == TK_BAD) mode_d = M_HALT;
              else idle_go = 1'b1;
            end
          end
          M_LINE: if (c == CH_LF) mode_d = M_IDLE;
          M_BLOCK: if (c == "*") mode_d = M_BSTAR;
          M_BSTAR: begin
            if (c == "/") mode_d = M_IDLE;
            else if (c != "*") mode_d = M_BLOCK;
          end
          M_STR: begin
            cnt_d = cnt_inc;
            if (c == CH_BSLASH) begin
              mode_d = M_ESC;
            end else if (c == quote_q) begin
              grp_d.tok[grp_d.n] = mk(TK_STRING, sline_q, start_q, cnt_inc, '0, '0, '0);
              grp_d.n = grp_d.n + 2'd1;
              mode_d  = M_IDLE;
            end
          end
          M_ESC: begin
            cnt_d  = cnt_inc;
            mode_d = M_STR;
          end
          M_INT: begin
            if (is_digit(c)) begin
              int_d = int_next;
              cnt_d = cnt_inc;
            end else if (c == ".") begin
              mode_d = M_NDOT;
            end else begin
              grp_d.tok[grp_d.n] = mk(TK_NUMBER, sline_q, start_q, cnt_q, int_q, frac_q, fc_q);
              grp_d.n = grp_d.n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_NDOT: begin
            if (is_digit(c)) begin
              cnt_d  = cnt_inc2;
              frac_d = 30'(dig);
              fc_d   = 4'd1;
              mode_d = M_FRAC;
            end else begin
              // The held dot becomes a dot operator, or a range with a second dot.
              grp_d.tok[grp_d.n] = mk(TK_NUMBER, sline_q, start_q, cnt_q, int_q, frac_q, fc_q);
              grp_d.n = grp_d.n + 2'd1;
              pend_d  = ".";
              start_d = off_prev;
              sline_d = line_q;
              if (c == ".") begin
                grp_d.tok[grp_d.n] = mk(TK_RANGE, line_q, off_prev, 16'd2, '0, '0, '0);
                grp_d.n = grp_d.n + 2'd1;
                mode_d  = M_IDLE;
              end else begin
                grp_d.tok[grp_d.n] = mk(TK_DOT, line_q, off_prev, 16'd1, '0, '0, '0);
                grp_d.n = grp_d.n + 2'd1;
                idle_go = 1'b1;
              end
            end
          end
          M_FRAC: begin
            if (is_digit(c)) begin
              cnt_d = cnt_inc;
              if (fc_q < FRAC_KEEP) begin
                frac_d = frac_next;
                fc_d   = fc_q + 4'd1;
              end
            end else begin
              grp_d.tok[grp_d.n] = mk(TK_NUMBER, sline_q, start_q, cnt_q, int_q, frac_q, fc_q);
              grp_d.n = grp_d.n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_word(c)) begin
              buf_we = (cnt_q < 16'(KEYWORD_CHARS));
              cnt_d  = cnt_inc;
            end else begin
              grp_d.tok[grp_d.n] = mk(kw_kind(name_w, cnt_q), sline_q, start_q, cnt_q,
                                      '0, '0, '0);
              grp_d.n = grp_d.n + 2'd1;
              idle_go = 1'b1;
            end
          end
          default: mode_d = M_HALT;
        endcase

        // Start of a new token on this byte.
        if (idle_go) begin
          mode_d = M_IDLE;
          if (!is_space(c)) begin
            start_d = off_q;
            sline_d = line_q;
            cnt_d   = 16'd1;
            if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              quote_d = c;
              mode_d  = M_STR;
            end else if (is_digit(c)) begin
              int_d  = 32'(dig);
              frac_d = '0;
              fc_d   = '0;
              mode_d = M_INT;
            end else if (is_alpha(c) || c == "_") begin
              buf_we  = 1'b1;
              buf_idx = '0;
              mode_d  = M_IDENT;
            end else if (starts_pair(c)) begin
              pend_d = c;
              mode_d = M_OP;
            end else begin
              grp_d.tok[grp_d.n] = mk(one_kind(c), line_q, off_q, 16'd1, '0, '0, '0);
              grp_d.n = grp_d.n + 2'd1;
              if (one_kind(c) == TK_BAD) mode_d = M_HALT;
            end
          end
        end

        // Position counters.
        if (c == CH_LF && line_q != LINE_MAX) line_d = line_q + 20'd1;
        off_d = off_q + OFFSET_BITS'(1);
      end
    end
  end

  assign push_o = (grp_d.n != 2'd0);
  assign grp_o  = grp_d;

  // Lexer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pend_q  <= '0;
      quote_q <= '0;
      cnt_q   <= '0;
      start_q <= '0;
      sline_q <= 20'd1;
      line_q  <= 20'd1;
      off_q   <= '0;
      int_q   <= '0;
      frac_q  <= '0;
      fc_q    <= '0;
    end else begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      quote_q <= quote_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      sline_q <= sline_d;
      line_q  <= line_d;
      off_q   <= off_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      fc_q    <= fc_d;
    end
  end

  // Name bytes for the keyword compare.
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_q[buf_idx] <= c;
  end

endmodule
`default_nettype wire

[rtl/core/sbt_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module sbt_fifo import sbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic nonempty_o,
  output grp_t rdata_o
);

  localparam int Depth = 2;

  grp_t       mem_q [Depth];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'(Depth));
  assign nonempty_o = (count_q != 2'd0);
  assign rdata_o    = mem_q[rptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d  = ~wptr_q;
      count_d = count_d + 2'd1;
    end
    if (pop_i) begin
      rptr_d  = ~rptr_q;
      count_d = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

[rtl/core/sbt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module sbt_back import sbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  grp_t head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic [1:0] idx_q, idx_d;
  tok_t       t;
  logic       last;
  logic       fire;

  // Hand out the tokens of the head group one word at a time.
  assign t           = head_i.tok[idx_q];
  assign last        = (idx_q == head_i.n - 2'd1);
  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i && !out_stall_i;
  assign pop_o       = fire && last;

  assign out_o.token_kind   = t.kind;
  assign out_o.token_line   = t.line;
  assign out_o.token_offset = t.offset;
  assign out_o.token_length = t.length;
  assign out_o.int_part     = t.int_part;
  assign out_o.frac_part    = t.frac_part;
  assign out_o.frac_digits  = t.frac_digits;
  assign out_o.last_of_run  = last;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) idx_d = '0;
    else if (fire) idx_d = idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/source_byte_tokenizer.sv]
// Streaming tokenizer. Source bytes enter on the input channel (in_valid_i,
// in_stall_o, in_i); a word with end_marker set closes the source. Tokens
// leave on the output channel (out_valid_o, out_stall_i, out_o), one token
// per word, with last_of_run set on the last token caused by an input word.
// An input word's tokens enter the queue as one group; the first is offered
// once it is at the queue head. Input runs at one byte per cycle while the
// queue is not full; the output moves one token per cycle while out_stall_i
// is low, so a byte that completes two or three tokens gives them in turn.
// A two-entry queue of token groups sits between the lexer and the output
// stage; the input stalls only while that queue is full, so a stalled
// receiver backs up into the queue and then into the input channel.
// Reset clears the lexer to the start of a new source at line 1, offset 0,
// and empties the queue. A bad character gives a bad-character token; later
// input is accepted and dropped until the next reset. An end word flushes a
// pending token and, unless it is bad, emits the end token and rearms.
`timescale 1ns / 1ps
`default_nettype none
`include "source_byte_tokenizer_defines.svh"
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int OFFSET_BITS   = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic in_fire;
  logic push, pop, full, nonempty;
  grp_t grp_w, head;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  // Lexer front end.
  sbt_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(in_fire),
    .in_i  (in_i),
    .push_o(push),
    .grp_o (grp_w)
  );

  // Token group queue.
  sbt_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wdata_i   (grp_w),
    .full_o    (full),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .rdata_o   (head)
  );

  // Output serializer.
  sbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A run that is not finished keeps offering words.
  `SBT_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_o.last_of_run, out_valid_o, "token run broken")
  // The end token closes its run and spans no bytes.
  `SBT_ASSERT_NOW(a_end_token, clk_i, rst_ni, out_valid_o && out_o.token_kind == TK_END, out_o.last_of_run && out_o.token_length == 16'd0, "bad end token")
  // Nothing follows a bad character within a run.
  `SBT_ASSERT_NOW(a_bad_last, clk_i, rst_ni, out_valid_o && out_o.token_kind == TK_BAD, out_o.last_of_run, "token after bad character")

endmodule
`default_nettype wire
